// ===== design/hlfe_pkg.sv =====
package hlfe_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;
   localparam int POS_W  = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam int HEADER_BYTES_DEFAULT   = 24;
   localparam int FRAME_OVERHEAD_DEFAULT = 26;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_BYTE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [BYTE_W-1:0] HEAD_BYTE_RESET   = 8'h00;
   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 16'hffff;

   typedef enum logic [1:0] {
      PHASE_HUNT = 2'd0,
      PHASE_HEAD = 2'd1,
      PHASE_BODY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_NORMAL    = 2'd0,
      STATUS_TRUNCATED = 2'd1,
      STATUS_OVERSIZE  = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] head_byte;
      logic [LEN_W-1:0]  max_payload;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              burst_end;
   } req_data_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [POS_W-1:0]  position;
      logic              frame_end;
      status_type        status;
   } rsp_data_type;

endpackage

// ===== design/hlfe_req_if.sv =====
interface hlfe_req_if;
   logic                          valid;
   logic                          ready;
   logic [hlfe_pkg::BYTE_W-1:0]   rx_byte;
   logic                          burst_end;

   modport source (output valid, output rx_byte, output burst_end, input ready);
   modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

// ===== design/hlfe_rsp_if.sv =====
interface hlfe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hlfe_pkg::BYTE_W-1:0]   frame_byte;
   logic [hlfe_pkg::POS_W-1:0]    position;
   logic                          frame_end;
   logic [1:0]                    status;

   modport source (output valid, output frame_byte, output position, output frame_end,
                   output status, input ready);
   modport sink   (input valid, input frame_byte, input position, input frame_end,
                   input status, output ready);
endinterface

// ===== design/head_length_frame_extractor.sv =====
// A request is registered on acceptance, and its result (if any) is then loaded into the
// output register, from which the receiver takes it. The block takes one request per
// cycle while the output register is not stalled; the header/length state machine advances
// once per request. An input register and an output register let one request be taken
// while a result waits. Synchronous active-high reset empties both registers,
// returns the parser to hunting and sets head_byte to 0 and max_payload to 65535.
module head_length_frame_extractor #(
   parameter int HEADER_BYTES   = hlfe_pkg::HEADER_BYTES_DEFAULT,
   parameter int FRAME_OVERHEAD = hlfe_pkg::FRAME_OVERHEAD_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   hlfe_req_if.sink                        req_bus,
   hlfe_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [hlfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hlfe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   hlfe_pkg::cfg_type       cfg_ff;
   logic                    in_valid_ff;
   hlfe_pkg::req_data_type  in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   hlfe_pkg::rsp_data_type  out_data_ff;

   logic                    advance;
   logic                    has_result;
   hlfe_pkg::rsp_data_type  result;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign out_valid_in  = advance ? has_result : (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte   <= hlfe_pkg::HEAD_BYTE_RESET;
         cfg_ff.max_payload <= hlfe_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hlfe_pkg::CSR_HEAD_BYTE:   cfg_ff.head_byte   <= csr_wdata[hlfe_pkg::BYTE_W-1:0];
            hlfe_pkg::CSR_MAX_PAYLOAD: cfg_ff.max_payload <= csr_wdata[hlfe_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= req_bus.valid ? 1'b1 : (in_valid_ff && !advance);
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_data_ff.rx_byte   <= req_bus.rx_byte;
         in_data_ff.burst_end <= req_bus.burst_end;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   hlfe_core #(
      .HEADER_BYTES   (HEADER_BYTES),
      .FRAME_OVERHEAD (FRAME_OVERHEAD)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .cfg        (cfg_ff),
      .req_data   (in_data_ff),
      .has_result (has_result),
      .rsp_data   (result)
   );

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.frame_byte = out_data_ff.frame_byte;
   assign rsp_bus.position   = out_data_ff.position;
   assign rsp_bus.frame_end  = out_data_ff.frame_end;
   assign rsp_bus.status     = out_data_ff.status;

endmodule

// ===== design/hlfe_core.sv =====
module hlfe_core #(
   parameter int HEADER_BYTES   = hlfe_pkg::HEADER_BYTES_DEFAULT,
   parameter int FRAME_OVERHEAD = hlfe_pkg::FRAME_OVERHEAD_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  hlfe_pkg::cfg_type      cfg,
   input  hlfe_pkg::req_data_type req_data,
   output logic                   has_result,
   output hlfe_pkg::rsp_data_type rsp_data
);

   localparam logic [hlfe_pkg::POS_W-1:0] POS_LEN_HIGH = hlfe_pkg::POS_W'(HEADER_BYTES - 2);
   localparam logic [hlfe_pkg::POS_W-1:0] POS_LEN_LOW  = hlfe_pkg::POS_W'(HEADER_BYTES - 1);
   localparam logic [hlfe_pkg::POS_W-1:0] OVERHEAD     = hlfe_pkg::POS_W'(FRAME_OVERHEAD);

   hlfe_pkg::phase_type               phase_ff, phase_in;
   logic [hlfe_pkg::POS_W-1:0]        offset_ff, offset_in;
   logic [hlfe_pkg::BYTE_W-1:0]       len_high_ff, len_high_in;
   logic [hlfe_pkg::POS_W-1:0]        total_ff, total_in;

   logic [hlfe_pkg::LEN_W-1:0]        length;
   logic [hlfe_pkg::POS_W-1:0]        new_total;
   logic [hlfe_pkg::POS_W:0]          pos_next;
   logic                              at_end_known;
   logic                              at_end_new;

   assign length       = {len_high_ff, req_data.rx_byte};
   assign new_total    = {1'b0, length} + OVERHEAD;
   assign pos_next     = {1'b0, offset_ff} + {{hlfe_pkg::POS_W{1'b0}}, 1'b1};
   assign at_end_known = pos_next >= {1'b0, total_ff};
   assign at_end_new   = pos_next >= {1'b0, new_total};

   always_comb begin
      phase_in    = phase_ff;
      offset_in   = offset_ff;
      len_high_in = len_high_ff;
      total_in    = total_ff;
      has_result  = 1'b0;
      rsp_data.frame_byte = req_data.rx_byte;
      rsp_data.position   = offset_ff;
      rsp_data.frame_end  = 1'b0;
      rsp_data.status     = hlfe_pkg::STATUS_NORMAL;

      case (phase_ff)
         hlfe_pkg::PHASE_HEAD: begin
            has_result = 1'b1;
            if (offset_ff == POS_LEN_HIGH) begin
               len_high_in = req_data.rx_byte;
            end
            if (offset_ff == POS_LEN_LOW && length > cfg.max_payload) begin
               rsp_data.frame_end = 1'b1;
               rsp_data.status    = hlfe_pkg::STATUS_OVERSIZE;
               phase_in = hlfe_pkg::PHASE_HUNT;
            end else if (offset_ff == POS_LEN_LOW && at_end_new) begin
               // The declared frame is no longer than what has already arrived.
               rsp_data.frame_end = 1'b1;
               phase_in = hlfe_pkg::PHASE_HUNT;
            end else if (req_data.burst_end) begin
               rsp_data.frame_end = 1'b1;
               rsp_data.status    = hlfe_pkg::STATUS_TRUNCATED;
               phase_in = hlfe_pkg::PHASE_HUNT;
            end else begin
               offset_in = pos_next[hlfe_pkg::POS_W-1:0];
               if (offset_ff == POS_LEN_LOW) begin
                  phase_in = hlfe_pkg::PHASE_BODY;
                  total_in = new_total;
               end
            end
         end
         hlfe_pkg::PHASE_BODY: begin
            has_result = 1'b1;
            if (at_end_known) begin
               rsp_data.frame_end = 1'b1;
               phase_in = hlfe_pkg::PHASE_HUNT;
            end else if (req_data.burst_end) begin
               rsp_data.frame_end = 1'b1;
               rsp_data.status    = hlfe_pkg::STATUS_TRUNCATED;
               phase_in = hlfe_pkg::PHASE_HUNT;
            end else begin
               offset_in = pos_next[hlfe_pkg::POS_W-1:0];
            end
         end
         default: begin
            // Hunting; the unused phase code also lands here.
            phase_in = hlfe_pkg::PHASE_HUNT;
            if (req_data.rx_byte == cfg.head_byte) begin
               has_result = 1'b1;
               rsp_data.position = '0;
               if (req_data.burst_end) begin
                  rsp_data.frame_end = 1'b1;
                  rsp_data.status    = hlfe_pkg::STATUS_TRUNCATED;
               end else begin
                  phase_in  = hlfe_pkg::PHASE_HEAD;
                  offset_in = hlfe_pkg::POS_W'(1);
               end
            end
         end
      endcase

      if (phase_in == hlfe_pkg::PHASE_HUNT) begin
         offset_in   = '0;
         len_high_in = '0;
         total_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= hlfe_pkg::PHASE_HUNT;
         offset_ff   <= '0;
         len_high_ff <= '0;
         total_ff    <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         offset_ff   <= offset_in;
         len_high_ff <= len_high_in;
         total_ff    <= total_in;
      end
   end

   a_status_only_at_end : assert property (@(posedge clock) disable iff (reset)
      step_en && has_result && !rsp_data.frame_end |-> rsp_data.status == hlfe_pkg::STATUS_NORMAL)
      else $error("nonzero status on a byte that does not end its frame");

   a_end_restarts_hunt : assert property (@(posedge clock) disable iff (reset)
      step_en && has_result && rsp_data.frame_end |=> phase_ff == hlfe_pkg::PHASE_HUNT)
      else $error("frame ended but hunting did not restart");

   a_hunt_offset_zero : assert property (@(posedge clock) disable iff (reset)
      phase_ff != hlfe_pkg::PHASE_HEAD && phase_ff != hlfe_pkg::PHASE_BODY |-> offset_ff == '0)
      else $error("byte offset not cleared while hunting");

   a_body_has_total : assert property (@(posedge clock) disable iff (reset)
      phase_ff == hlfe_pkg::PHASE_BODY |-> offset_ff < total_ff)
      else $error("body offset reached the frame length");

endmodule

// ===== verif/tb_head_length_frame_extractor.sv =====
`timescale 1ns / 100ps

module tb_head_length_frame_extractor;

   localparam int LENGTH_HIGH_POS = hlfe_pkg::HEADER_BYTES_DEFAULT - 2;
   localparam int LENGTH_LOW_POS  = hlfe_pkg::HEADER_BYTES_DEFAULT - 1;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int PHASE_BUDGET    = 200;

   // Tracks the deframer state for every accepted request and holds the
   // result bytes that are still due from the block.
   class frame_byte_tracker;
      logic [hlfe_pkg::BYTE_W-1:0] head_byte;
      logic [hlfe_pkg::LEN_W-1:0]  max_payload;
      hlfe_pkg::phase_type         phase;
      logic [hlfe_pkg::POS_W-1:0]  byte_offset;
      logic [hlfe_pkg::BYTE_W-1:0] length_high;
      int                          frame_total;
      hlfe_pkg::rsp_data_type      due_bytes[$];
      int                          mismatches;

      function new();
         head_byte   = hlfe_pkg::HEAD_BYTE_RESET;
         max_payload = hlfe_pkg::MAX_PAYLOAD_RESET;
         mismatches  = 0;
         restart_hunt();
      endfunction

      function void restart_hunt();
         phase       = hlfe_pkg::PHASE_HUNT;
         byte_offset = '0;
         length_high = '0;
         frame_total = 0;
      endfunction

      function void set_register(logic [hlfe_pkg::CSR_INDEX_W-1:0] index,
                                 logic [hlfe_pkg::CSR_DATA_W-1:0] value);
         if (index == hlfe_pkg::CSR_HEAD_BYTE) begin
            head_byte = value[hlfe_pkg::BYTE_W-1:0];
         end else if (index == hlfe_pkg::CSR_MAX_PAYLOAD) begin
            max_payload = value[hlfe_pkg::LEN_W-1:0];
         end
      endfunction

      function void owe(logic [hlfe_pkg::BYTE_W-1:0] value, int pos, logic last,
                        hlfe_pkg::status_type status);
         hlfe_pkg::rsp_data_type item;
         item.frame_byte = value;
         item.position   = hlfe_pkg::POS_W'(pos);
         item.frame_end  = last;
         item.status     = status;
         due_bytes.push_back(item);
      endfunction

      function void take_byte(logic [hlfe_pkg::BYTE_W-1:0] value, logic last);
         int pos;
         int length;
         if (phase != hlfe_pkg::PHASE_HEAD && phase != hlfe_pkg::PHASE_BODY) begin
            if (value != head_byte) begin
               return;
            end
            if (last) begin
               owe(value, 0, 1'b1, hlfe_pkg::STATUS_TRUNCATED);
               restart_hunt();
            end else begin
               owe(value, 0, 1'b0, hlfe_pkg::STATUS_NORMAL);
               phase       = hlfe_pkg::PHASE_HEAD;
               byte_offset = hlfe_pkg::POS_W'(1);
            end
            return;
         end
         pos = int'(byte_offset);
         if (phase == hlfe_pkg::PHASE_HEAD) begin
            if (pos == LENGTH_HIGH_POS) begin
               length_high = value;
            end
            if (pos == LENGTH_LOW_POS) begin
               length = int'({length_high, value});
               // An oversize length ends the frame even when the burst ends here.
               if (length > int'(max_payload)) begin
                  owe(value, pos, 1'b1, hlfe_pkg::STATUS_OVERSIZE);
                  restart_hunt();
                  return;
               end
               frame_total = length + hlfe_pkg::FRAME_OVERHEAD_DEFAULT;
               phase       = hlfe_pkg::PHASE_BODY;
               if (pos + 1 >= frame_total) begin
                  owe(value, pos, 1'b1, hlfe_pkg::STATUS_NORMAL);
                  restart_hunt();
                  return;
               end
            end
         end else if (pos + 1 >= frame_total) begin
            owe(value, pos, 1'b1, hlfe_pkg::STATUS_NORMAL);
            restart_hunt();
            return;
         end
         if (last) begin
            owe(value, pos, 1'b1, hlfe_pkg::STATUS_TRUNCATED);
            restart_hunt();
         end else begin
            owe(value, pos, 1'b0, hlfe_pkg::STATUS_NORMAL);
            byte_offset = hlfe_pkg::POS_W'(pos + 1);
         end
      endfunction

      function void flag(string field, int want, int got);
         mismatches++;
         $error("%s: expected %0d, got %0d", field, want, got);
      endfunction

      function void check_byte(hlfe_pkg::rsp_data_type got);
         hlfe_pkg::rsp_data_type want;
         if (due_bytes.size() == 0) begin
            flag("frame_byte (nothing due)", -1, int'(got.frame_byte));
            return;
         end
         want = due_bytes.pop_front();
         if (got.frame_byte !== want.frame_byte) begin
            flag("frame_byte", int'(want.frame_byte), int'(got.frame_byte));
         end
         if (got.position !== want.position) begin
            flag("position", int'(want.position), int'(got.position));
         end
         if (got.frame_end !== want.frame_end) begin
            flag("frame_end", int'(want.frame_end), int'(got.frame_end));
         end
         if (got.status !== want.status) begin
            flag("status", int'(want.status), int'(got.status));
         end
      endfunction

      function bit pending();
         return due_bytes.size() != 0;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                             csr_we;
   logic [hlfe_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [hlfe_pkg::CSR_DATA_W-1:0]  csr_wdata;

   hlfe_req_if req_bus ();
   hlfe_rsp_if rsp_bus ();

   head_length_frame_extractor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_byte_tracker tracker = new();

   logic [hlfe_pkg::BYTE_W-1:0] cur_head;
   logic [hlfe_pkg::LEN_W-1:0]  cur_limit;
   bit                          req_steady;
   bit                          rsp_steady;
   bit                          hold_off_requested;
   int                          sent_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap(bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic push_byte(input logic [hlfe_pkg::BYTE_W-1:0] value, input logic last);
      int gap;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.rx_byte   <= value;
      req_bus.burst_end <= last;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_byte(value, last);
      sent_count++;
   endtask

   // Waits until every due byte is back and any dropped bytes have left the block.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (tracker.pending()) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [hlfe_pkg::BYTE_W-1:0] head,
                                input logic [hlfe_pkg::LEN_W-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= hlfe_pkg::CSR_HEAD_BYTE;
      csr_wdata <= hlfe_pkg::CSR_DATA_W'(head);
      @(posedge clock);
      tracker.set_register(hlfe_pkg::CSR_HEAD_BYTE, hlfe_pkg::CSR_DATA_W'(head));
      csr_index <= hlfe_pkg::CSR_MAX_PAYLOAD;
      csr_wdata <= limit;
      @(posedge clock);
      tracker.set_register(hlfe_pkg::CSR_MAX_PAYLOAD, limit);
      csr_we    <= 1'b0;
      cur_head  = head;
      cur_limit = limit;
   endtask

   // Sends the first byte_count bytes of a frame that carries length_field.
   task automatic send_frame(input logic [hlfe_pkg::LEN_W-1:0] length_field,
                             input int byte_count, input bit cut);
      logic [hlfe_pkg::BYTE_W-1:0] value;
      for (int pos = 0; pos < byte_count; pos++) begin
         if (pos == 0) begin
            value = cur_head;
         end else if (pos == LENGTH_HIGH_POS) begin
            value = length_field[15:8];
         end else if (pos == LENGTH_LOW_POS) begin
            value = length_field[7:0];
         end else begin
            value = hlfe_pkg::BYTE_W'($urandom);
         end
         push_byte(value, cut && (pos == byte_count - 1));
      end
   endtask

   // Line noise; the burst always ends on the last byte so that hunting resumes.
   task automatic send_noise(input int count);
      logic [hlfe_pkg::BYTE_W-1:0] value;
      for (int i = 0; i < count; i++) begin
         value = hlfe_pkg::BYTE_W'($urandom);
         if (value == cur_head && $urandom_range(0, 3) != 0) begin
            value = ~value;
         end
         push_byte(value, (i == count - 1) || ($urandom_range(0, 7) == 0));
      end
   endtask

   task automatic send_mix(input int budget);
      int goal;
      int roll;
      int cap;
      int length;
      goal = sent_count + budget;
      while (sent_count < goal) begin
         roll   = $urandom_range(0, 99);
         cap    = (int'(cur_limit) < 40) ? int'(cur_limit) : 40;
         length = $urandom_range(0, cap);
         if (roll < 55) begin
            send_frame(hlfe_pkg::LEN_W'(length), length + hlfe_pkg::FRAME_OVERHEAD_DEFAULT,
                       $urandom_range(0, 3) == 0);
         end else if (roll < 75) begin
            send_frame(hlfe_pkg::LEN_W'(length),
                       $urandom_range(1, length + hlfe_pkg::FRAME_OVERHEAD_DEFAULT - 1),
                       1'b1);
         end else if (roll < 87 && cur_limit != 16'hffff) begin
            send_frame(hlfe_pkg::LEN_W'($urandom_range(int'(cur_limit) + 1, 65535)),
                       hlfe_pkg::HEADER_BYTES_DEFAULT, $urandom_range(0, 1) == 1);
         end else begin
            send_noise($urandom_range(1, 8));
         end
      end
   endtask

   always @(posedge clock) begin
      hlfe_pkg::rsp_data_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.frame_byte = rsp_bus.frame_byte;
         got.position   = rsp_bus.position;
         got.frame_end  = rsp_bus.frame_end;
         got.status     = hlfe_pkg::status_type'(rsp_bus.status);
         tracker.check_byte(got);
      end
   end

   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap(rsp_steady);
         if (hold_off_requested) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_requested = 1'b0;
         end else if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [hlfe_pkg::BYTE_W-1:0] heads[6];
      logic [hlfe_pkg::LEN_W-1:0]  limits[6];
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.rx_byte   <= '0;
      req_bus.burst_end <= 1'b0;
      csr_we            <= 1'b0;
      csr_index         <= hlfe_pkg::CSR_HEAD_BYTE;
      csr_wdata         <= '0;
      cur_head           = hlfe_pkg::HEAD_BYTE_RESET;
      cur_limit          = hlfe_pkg::MAX_PAYLOAD_RESET;
      req_steady         = 1'b0;
      rsp_steady         = 1'b0;
      hold_off_requested = 1'b0;
      sent_count         = 0;
      heads  = '{8'ha5, 8'hff, 8'h00, hlfe_pkg::BYTE_W'($urandom),
                 hlfe_pkg::BYTE_W'($urandom), 8'h7e};
      limits = '{16'd40, 16'd0, 16'hffff, hlfe_pkg::LEN_W'($urandom_range(0, 60)),
                 16'd12, 16'd1000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a burst ending while hunting, a stray byte, and a head
      // byte that is also the last of its burst.
      push_byte(8'h55, 1'b1);
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b1);
      settle();
      // Oversize length on a byte that also ends the burst.
      load_settings(8'h00, 16'hfffe);
      send_frame(16'hffff, hlfe_pkg::HEADER_BYTES_DEFAULT, 1'b1);

      for (int p = 0; p < 6; p++) begin
         settle();
         load_settings(heads[p], limits[p]);
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         if (p == 0) begin
            // The receiver stalls while a whole frame is offered, so the block backs up.
            hold_off_requested = 1'b1;
            send_frame(16'd30, 30 + hlfe_pkg::FRAME_OVERHEAD_DEFAULT, 1'b0);
         end
         send_mix(PHASE_BUDGET);
      end

      // A frame of the largest length, cut short by the end of its burst.
      settle();
      load_settings(8'h3c, 16'hffff);
      req_steady = 1'b1;
      send_frame(16'hffff, 2 * hlfe_pkg::HEADER_BYTES_DEFAULT, 1'b1);

      req_bus.valid <= 1'b0;
      while (tracker.pending()) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
